// File: rtl/hexw_pkg.sv
// Constants, types and a helper function shared by the Intel HEX record writer.
`default_nettype none

package hexw_pkg;

  // Record and chunk geometry.
  localparam int RECORD_BYTES = 24;
  localparam int CHUNK_BYTES  = 8096;
  localparam int ADDR_W       = 16;
  localparam int FILL_W       = $clog2(RECORD_BYTES + 1);
  localparam int IDX_W        = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
  localparam int CHUNK_W      = $clog2(CHUNK_BYTES + 1);

  // Input item function codes.
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_DATA  = 2'd1;
  localparam logic [1:0] FUNC_FLUSH = 2'd2;
  localparam logic [1:0] FUNC_EOF   = 2'd3;

  // ASCII characters used by the record format.
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_NUL     = 8'h00;

  // Fixed end-of-file record text.
  localparam int EOF_LEN = 12;
  localparam logic [7:0] EOF_TEXT [EOF_LEN] = '{
    8'h3A, 8'h30, 8'h30, 8'h30, 8'h30, 8'h30,
    8'h30, 8'h30, 8'h31, 8'h46, 8'h46, 8'h0A
  };

  // Command from the control logic to the character sequencer.
  typedef struct packed {
    logic              start;
    logic              eof;
    logic [FILL_W-1:0] count;
    logic [ADDR_W-1:0] addr;
  } emit_cmd_t;

  // Upper-case hex digit for one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nibble);
    logic [7:0] c;
    if (nibble < 4'd10) begin
      c = 8'h30 + {4'h0, nibble};
    end else begin
      c = 8'h37 + {4'h0, nibble};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/hexw_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module hexw_ram #(
  parameter int DEPTH = 24,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data register holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/hexw_emitter.sv
// Sequencer: walks a record out of the buffer, one character per cycle unless stalled.
`default_nettype none

module hexw_emitter (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire hexw_pkg::emit_cmd_t       cmd,
  input  wire logic [7:0]                rd_data,
  output logic                           rd_en,
  output logic [hexw_pkg::IDX_W-1:0]     rd_addr,
  output logic                           busy,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [7:0]                     out_char,
  output logic                           last_char
);

  import hexw_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_HEAD  = 5'b00010,
    ST_DATA  = 5'b00100,
    ST_TRAIL = 5'b01000,
    ST_EOF   = 5'b10000
  } state_t;

  state_t            state, state_next;
  logic [3:0]        pos, pos_next;
  logic              nib, nib_next;
  logic [IDX_W-1:0]  byte_idx, byte_idx_next;
  logic [FILL_W-1:0] count;
  logic [ADDR_W-1:0] addr;
  logic [7:0]        sum, sum_next;

  logic [7:0] count8;
  logic [7:0] chk;
  logic       load;
  logic       advance;
  logic       last_byte;
  logic [7:0] ch;
  logic       ch_last;

  assign count8    = 8'(count);
  assign chk       = 8'h00 - sum;
  assign load      = !out_valid || out_ready;
  assign busy      = (state != ST_IDLE);
  assign advance   = busy && load;
  assign last_byte = ((FILL_W'(byte_idx) + FILL_W'(1)) == count);

  // Character selection and sequencing.
  always_comb begin
    state_next    = state;
    pos_next      = pos;
    nib_next      = nib;
    byte_idx_next = byte_idx;
    sum_next      = sum;
    ch            = CH_NUL;
    ch_last       = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = byte_idx + IDX_W'(1);
    case (state)
      ST_IDLE: begin
        pos_next      = '0;
        nib_next      = 1'b0;
        byte_idx_next = '0;
        // Seed the checksum with the header bytes of the next record.
        sum_next      = 8'(cmd.count) + cmd.addr[15:8] + cmd.addr[7:0];
      end
      ST_HEAD: begin
        // Keep the first data byte loaded while the header goes out.
        rd_en   = 1'b1;
        rd_addr = '0;
        case (pos)
          4'd0:    ch = CH_COLON;
          4'd1:    ch = hex_char(count8[7:4]);
          4'd2:    ch = hex_char(count8[3:0]);
          4'd3:    ch = hex_char(addr[15:12]);
          4'd4:    ch = hex_char(addr[11:8]);
          4'd5:    ch = hex_char(addr[7:4]);
          4'd6:    ch = hex_char(addr[3:0]);
          default: ch = CH_ZERO;
        endcase
        if (advance) begin
          if (pos == 4'd8) begin
            state_next = ST_DATA;
            pos_next   = '0;
          end else begin
            pos_next = pos + 4'd1;
          end
        end
      end
      ST_DATA: begin
        ch = nib ? hex_char(rd_data[3:0]) : hex_char(rd_data[7:4]);
        if (advance) begin
          if (!nib) begin
            sum_next = sum + rd_data;
            nib_next = 1'b1;
          end else begin
            nib_next = 1'b0;
            if (last_byte) begin
              state_next = ST_TRAIL;
              pos_next   = '0;
            end else begin
              // Fetch the next byte as the low digit of this one leaves.
              rd_en         = 1'b1;
              byte_idx_next = byte_idx + IDX_W'(1);
            end
          end
        end
      end
      ST_TRAIL: begin
        case (pos)
          4'd0:    ch = hex_char(chk[7:4]);
          4'd1:    ch = hex_char(chk[3:0]);
          4'd2:    ch = CH_NEWLINE;
          default: ch = CH_NUL;
        endcase
        ch_last = (pos == 4'd4);
        if (advance) begin
          if (ch_last) begin
            state_next = ST_IDLE;
          end else begin
            pos_next = pos + 4'd1;
          end
        end
      end
      ST_EOF: begin
        ch      = EOF_TEXT[pos];
        ch_last = (pos == 4'(EOF_LEN - 1));
        if (advance) begin
          if (ch_last) begin
            state_next = ST_IDLE;
          end else begin
            pos_next = pos + 4'd1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_IDLE && cmd.start) begin
        state <= cmd.eof ? ST_EOF : ST_HEAD;
      end else begin
        state <= state_next;
      end
      if (load) begin
        out_valid <= busy;
      end
    end
  end

  // Record fields, counters and the output character register.
  always_ff @(posedge clk) begin
    pos      <= pos_next;
    nib      <= nib_next;
    byte_idx <= byte_idx_next;
    sum      <= sum_next;
    if (state == ST_IDLE && cmd.start) begin
      count <= cmd.count;
      addr  <= cmd.addr;
    end
    if (advance) begin
      out_char  <= ch;
      last_char <= ch_last;
    end
  end

endmodule

`default_nettype wire

// File: rtl/intel_hex_record_writer.sv
// Top level of the Intel HEX record writer: item control, byte buffer and sequencer.
//
// Usage: items enter on the in_valid/in_ready channel (func, byte_value,
// section_base). Each transaction on the output channel (out_valid/out_ready)
// carries one ASCII character, out_char; last_char marks the final character
// that an item causes. Items that cause no output (most data bytes, a section
// start or end with nothing buffered) are taken one per cycle.
// A data record of N bytes leaves as 14 + 2N characters, one per cycle while
// the receiver does not stall; a full 24-byte record is 62 characters. The
// end-of-file record is 12 characters. The output rate is set by the
// character sequencer, which emits one character per cycle unless the
// receiver stalls, and reads one buffered byte from the buffer memory for
// every two characters.
// While a record is being sent in_ready is low; it rises as the last
// character enters the output register, so the next item can be taken while
// that character still waits. A stalled receiver simply holds the sequencer.
// Reset (rst, synchronous) clears the fill count, addresses, chunk count and
// the offset register; the buffer memory needs no clearing. address_offset
// is written through cfg_we/cfg_wdata; it is to be written only while the
// block is idle, and the block itself does not enforce this.
`default_nettype none

module intel_hex_record_writer (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [hexw_pkg::ADDR_W-1:0] cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  func,
  input  wire logic [7:0]                  byte_value,
  input  wire logic [hexw_pkg::ADDR_W-1:0] section_base,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [7:0]                       out_char,
  output logic                             last_char
);

  import hexw_pkg::*;

  logic [ADDR_W-1:0]  address_offset;
  logic [FILL_W-1:0]  fill_count, fill_count_next;
  logic [ADDR_W-1:0]  record_address, record_address_next;
  logic [ADDR_W-1:0]  next_address, next_address_next;
  logic [CHUNK_W-1:0] chunk_count, chunk_count_next;

  emit_cmd_t         cmd;
  logic              accept;
  logic              busy;
  logic              ram_we;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [7:0]        ram_rdata;
  logic [FILL_W-1:0] fill_inc;
  logic [CHUNK_W:0]  chunk_inc;
  logic [ADDR_W-1:0] data_rec_addr;

  assign in_ready      = !busy;
  assign accept        = in_valid && in_ready;
  assign fill_inc      = fill_count + FILL_W'(1);
  assign chunk_inc     = {1'b0, chunk_count} + (CHUNK_W + 1)'(1);
  assign data_rec_addr = (fill_count == '0) ? next_address : record_address;

  // Item decode: buffer update and record launch.
  always_comb begin
    fill_count_next     = fill_count;
    record_address_next = record_address;
    next_address_next   = next_address;
    chunk_count_next    = chunk_count;
    cmd                 = '0;
    ram_we              = 1'b0;
    if (accept) begin
      case (func)
        FUNC_START: begin
          cmd.start           = (fill_count != '0);
          cmd.count           = fill_count;
          cmd.addr            = record_address;
          fill_count_next     = '0;
          next_address_next   = section_base - address_offset;
          record_address_next = section_base - address_offset;
          chunk_count_next    = '0;
        end
        FUNC_DATA: begin
          ram_we              = 1'b1;
          record_address_next = data_rec_addr;
          next_address_next   = next_address + ADDR_W'(1);
          cmd.count           = fill_inc;
          cmd.addr            = data_rec_addr;
          if (chunk_inc >= (CHUNK_W + 1)'(CHUNK_BYTES)) begin
            // Chunk boundary: send what is held, start a new chunk.
            cmd.start        = 1'b1;
            fill_count_next  = '0;
            chunk_count_next = '0;
          end else if (fill_inc >= FILL_W'(RECORD_BYTES)) begin
            cmd.start        = 1'b1;
            fill_count_next  = '0;
            chunk_count_next = chunk_inc[CHUNK_W-1:0];
          end else begin
            fill_count_next  = fill_inc;
            chunk_count_next = chunk_inc[CHUNK_W-1:0];
          end
        end
        FUNC_FLUSH: begin
          cmd.start        = (fill_count != '0);
          cmd.count        = fill_count;
          cmd.addr         = record_address;
          fill_count_next  = '0;
          chunk_count_next = '0;
        end
        FUNC_EOF: begin
          // Pending bytes are dropped; only the end-of-file record goes out.
          cmd.start        = 1'b1;
          cmd.eof          = 1'b1;
          fill_count_next  = '0;
          chunk_count_next = '0;
        end
        default: begin
          cmd = '0;
        end
      endcase
    end
  end

  // Control registers and the offset register.
  always_ff @(posedge clk) begin
    if (rst) begin
      address_offset <= '0;
      fill_count     <= '0;
      record_address <= '0;
      next_address   <= '0;
      chunk_count    <= '0;
    end else begin
      if (cfg_we) begin
        address_offset <= cfg_wdata;
      end
      fill_count     <= fill_count_next;
      record_address <= record_address_next;
      next_address   <= next_address_next;
      chunk_count    <= chunk_count_next;
    end
  end

  // Byte buffer of the record being collected.
  hexw_ram #(
    .DEPTH (RECORD_BYTES),
    .WIDTH (8),
    .AW    (IDX_W)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_count[IDX_W-1:0]),
    .wdata (byte_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Character sequencer with the output register.
  hexw_emitter u_emit (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .rd_data   (ram_rdata),
    .rd_en     (ram_re),
    .rd_addr   (ram_raddr),
    .busy      (busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_char  (out_char),
    .last_char (last_char)
  );

  // An end-of-file item always starts a record, so input closes next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func == FUNC_EOF |=> !in_ready)
    else $error("end-of-file item did not start the sequencer");

  // A full buffer is always sent at once, so the fill count stays below a record.
  assert property (@(posedge clk) disable iff (rst)
    fill_count < FILL_W'(RECORD_BYTES))
    else $error("fill count reached a full record");

  // The chunk count restarts on reaching the chunk size.
  assert property (@(posedge clk) disable iff (rst)
    {1'b0, chunk_count} < (CHUNK_W + 1)'(CHUNK_BYTES))
    else $error("chunk count reached the chunk size");

  // A data item that fills the buffer must stop input for the record.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func == FUNC_DATA && fill_count == FILL_W'(RECORD_BYTES - 1)
    |=> !in_ready && fill_count == '0)
    else $error("full record was not launched");

endmodule

`default_nettype wire
